@@ hw/rtl/gcdcr_pkg.sv @@
// Shared constants and types of the GCD coprocessor register block.
package gcdcr_pkg;

   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int WORD_BYTES_DEFAULT = 4;
   localparam int NUM_CELLS          = 4;
   localparam int BUS_WIDTH          = 32;

   typedef enum logic [1:0] {
      MODE_READ  = 2'd0,
      MODE_WRITE = 2'd1,
      MODE_TICK  = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      CELL_OPA    = 2'd0,
      CELL_OPB    = 2'd1,
      CELL_START  = 2'd2,
      CELL_STATUS = 2'd3
   } cell_type;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_COMPARE = 2'd1,
      PH_SUB_A   = 2'd2,
      PH_SUB_B   = 2'd3
   } phase_type;

   typedef enum logic {
      SEQ_ACCEPT = 1'b0,
      SEQ_FINISH = 1'b1
   } seq_type;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

endpackage

@@ hw/rtl/gcd_coprocessor_registers_core.sv @@
// Register-mapped subtractive GCD coprocessor with bus read, write and tick words.
//
// Four registers sit from byte address csr_data (segment base) on, one every
// WORD_BYTES bytes: operand A / result, operand B, start and status. Each tick
// word runs one engine step (compare, subtract from A or subtract from B) and
// gives no response; a read or write word gives one response in the cycle after
// it is taken, but a result read answers only once the engine has stopped.
// A result read runs the engine to its end first, one step a cycle through the
// single shared subtractor; the request side is not ready meanwhile. Illegal
// accesses answer with tuser set.
module gcd_coprocessor_registers_core
   import gcdcr_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT,
   parameter int WORD_BYTES = WORD_BYTES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [63:0]          req_tdata,  // address[31:0], write_data[63:32]
   input  logic [1:0]           req_tuser,  // mode[1:0]
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [BUS_WIDTH-1:0] rsp_tdata,  // read_data[31:0]
   output logic                 rsp_tuser,  // access_status[0]
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [BUS_WIDTH-1:0] csr_data
);

   localparam int EXT_WIDTH = (DATA_WIDTH > BUS_WIDTH) ? DATA_WIDTH : BUS_WIDTH;

   logic [BUS_WIDTH-1:0]  seg_base_ff;
   logic [DATA_WIDTH-1:0] opa_ff, opa_in, opb_ff, opb_in;
   phase_type             phase_ff, phase_in;
   seq_type               seq_ff, seq_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [BUS_WIDTH-1:0]  rsp_data_ff, rsp_data_in;
   logic                  rsp_err_ff, rsp_err_in;

   logic                  accept;
   mode_type              mode;
   logic [BUS_WIDTH-1:0]  address, write_data, offset;
   logic                  in_range;
   cell_type              reg_sel;
   logic [EXT_WIDTH-1:0]  wdata_ext, opa_ext;
   logic [DATA_WIDTH-1:0] wr_val, sub_x, sub_y;
   logic [DATA_WIDTH:0]   diff;
   logic                  step_en;

   assign mode       = mode_type'(req_tuser);
   assign address    = req_tdata[31:0];
   assign write_data = req_tdata[63:32];
   assign csr_ready  = 1'b1;

   assign req_tready = (seq_ff == SEQ_ACCEPT) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_err_ff;

   assign offset   = address - seg_base_ff;
   assign in_range = offset < BUS_WIDTH'(NUM_CELLS * WORD_BYTES);

   always_comb begin
      reg_sel = CELL_OPA;
      for (int k = 1; k < NUM_CELLS; k++) begin
         if (offset >= BUS_WIDTH'(k * WORD_BYTES)) begin
            reg_sel = cell_type'(2'(k));
         end
      end
   end

   assign wdata_ext = EXT_WIDTH'(write_data);
   assign wr_val    = wdata_ext[DATA_WIDTH-1:0];
   assign opa_ext   = EXT_WIDTH'(opa_ff);

   // shared subtractor: borrow doubles as the magnitude compare
   assign sub_x = (phase_ff == PH_SUB_B) ? opb_ff : opa_ff;
   assign sub_y = (phase_ff == PH_SUB_B) ? opa_ff : opb_ff;
   assign diff  = {1'b0, sub_x} - {1'b0, sub_y};

   assign step_en = (accept && mode == MODE_TICK) || (seq_ff == SEQ_FINISH);

   always_comb begin
      opa_in       = opa_ff;
      opb_in       = opb_ff;
      phase_in     = phase_ff;
      seq_in       = seq_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_err_in   = rsp_err_ff;

      if (step_en) begin
         case (phase_ff)
            PH_COMPARE: begin
               if (opa_ff == '0 || opb_ff == '0) begin
                  phase_in = PH_IDLE;
               end else if (diff[DATA_WIDTH]) begin
                  phase_in = PH_SUB_B;
               end else if (diff[DATA_WIDTH-1:0] == '0) begin
                  phase_in = PH_IDLE;
               end else begin
                  phase_in = PH_SUB_A;
               end
            end
            PH_SUB_A: begin
               opa_in   = diff[DATA_WIDTH-1:0];
               phase_in = PH_COMPARE;
            end
            PH_SUB_B: begin
               opb_in   = diff[DATA_WIDTH-1:0];
               phase_in = PH_COMPARE;
            end
            default: phase_in = PH_IDLE;
         endcase
      end

      case (seq_ff)
         SEQ_ACCEPT: begin
            if (accept && (mode == MODE_READ || mode == MODE_WRITE)) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_err_in   = STATUS_OK;
               if (!in_range) begin
                  rsp_err_in = STATUS_ERR;
               end else if (mode == MODE_READ) begin
                  case (reg_sel)
                     CELL_OPA: begin
                        rsp_valid_in = 1'b0;
                        seq_in       = SEQ_FINISH;
                     end
                     CELL_STATUS: rsp_data_in = BUS_WIDTH'(phase_ff != PH_IDLE);
                     default:     rsp_err_in  = STATUS_ERR;
                  endcase
               end else begin
                  case (reg_sel)
                     CELL_OPA: opa_in = wr_val;
                     CELL_OPB: opb_in = wr_val;
                     CELL_START: begin
                        if (phase_ff == PH_IDLE) begin
                           phase_in = PH_COMPARE;
                        end
                     end
                     default: rsp_err_in = STATUS_ERR;
                  endcase
               end
            end
         end
         SEQ_FINISH: begin
            if (phase_ff == PH_IDLE) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = opa_ext[BUS_WIDTH-1:0];
               rsp_err_in   = STATUS_OK;
               seq_in       = SEQ_ACCEPT;
            end
         end
         default: seq_in = SEQ_ACCEPT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_base_ff  <= '0;
         phase_ff     <= PH_IDLE;
         seq_ff       <= SEQ_ACCEPT;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            seg_base_ff <= csr_data;
         end
         phase_ff     <= phase_in;
         seq_ff       <= seq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      opa_ff      <= opa_in;
      opb_ff      <= opb_in;
      rsp_data_ff <= rsp_data_in;
      rsp_err_ff  <= rsp_err_in;
   end

   a_sub_then_compare: assert property (@(posedge clock) disable iff (reset)
      (step_en && (phase_ff == PH_SUB_A || phase_ff == PH_SUB_B))
      |=> (phase_ff == PH_COMPARE))
      else $error("subtract step not followed by compare");

   a_finish_responds: assert property (@(posedge clock) disable iff (reset)
      (seq_ff == SEQ_FINISH && phase_ff == PH_IDLE)
      |=> (rsp_tvalid && seq_ff == SEQ_ACCEPT && rsp_tuser == STATUS_OK))
      else $error("result read did not respond once the engine stopped");

   a_no_req_while_finishing: assert property (@(posedge clock) disable iff (reset)
      (seq_ff == SEQ_FINISH) |-> !accept)
      else $error("request taken while the engine runs to its end");

   a_slot_kept: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("waiting response word overwritten");

endmodule

@@ verif/gcd_coprocessor_registers_core_test.sv @@
// Self-checking testbench of the register-mapped subtractive GCD coprocessor core.
import gcdcr_pkg::*;

typedef logic [DATA_WIDTH_DEFAULT-1:0] operand_type;

typedef struct packed {
   logic [BUS_WIDTH-1:0] read_data;
   logic                 access_status;
} bus_reply_type;

class gcd_reply_checker;
   logic [BUS_WIDTH-1:0] base;
   operand_type          opa;
   operand_type          opb;
   phase_type            phase;
   bus_reply_type        awaited_replies[$];
   int                   errors;

   function new();
      base   = '0;
      opa    = '0;
      opb    = '0;
      phase  = PH_IDLE;
      errors = 0;
   endfunction

   function void engine_step();
      case (phase)
         PH_COMPARE: begin
            if (opa == 0 || opb == 0) phase = PH_IDLE;
            else if (opa < opb) phase = PH_SUB_B;
            else if (opb < opa) phase = PH_SUB_A;
            else phase = PH_IDLE;
         end
         PH_SUB_A: begin
            opa   = opa - opb;
            phase = PH_COMPARE;
         end
         PH_SUB_B: begin
            opb   = opb - opa;
            phase = PH_COMPARE;
         end
         default: phase = PH_IDLE;
      endcase
   endfunction

   function void run_engine_out();
      operand_type x, y, t;
      if (phase == PH_SUB_A || phase == PH_SUB_B) engine_step();
      if (phase == PH_IDLE) return;
      if (opa != 0 && opb != 0) begin
         x = opa;
         y = opb;
         while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
         end
         opa = x;
         opb = x;
      end
      phase = PH_IDLE;
   endfunction

   // Estimate of the subtractions a result read would have to run through.
   function longint steps_to_settle();
      operand_type x, y, t;
      phase_type   ph;
      longint      total;
      x     = opa;
      y     = opb;
      ph    = phase;
      total = 0;
      if (ph == PH_SUB_A) begin
         x  = x - y;
         ph = PH_COMPARE;
      end else if (ph == PH_SUB_B) begin
         y  = y - x;
         ph = PH_COMPARE;
      end
      if (ph == PH_IDLE || x == 0 || y == 0) return 0;
      while (y != 0) begin
         total += longint'(x / y);
         t = x % y;
         x = y;
         y = t;
      end
      return total;
   endfunction

   function void take_bus_word(mode_type mode, logic [31:0] addr, logic [31:0] wdata);
      logic [31:0]   slot;
      bus_reply_type reply;
      if (mode == MODE_TICK) begin
         engine_step();
         return;
      end
      if (mode == MODE_NONE) return;
      slot                = (addr - base) / WORD_BYTES_DEFAULT;
      reply.read_data     = '0;
      reply.access_status = STATUS_OK;
      if (mode == MODE_READ) begin
         if (slot == 32'(CELL_OPA)) begin
            run_engine_out();
            reply.read_data = BUS_WIDTH'(opa);
         end else if (slot == 32'(CELL_STATUS)) begin
            reply.read_data = BUS_WIDTH'(phase != PH_IDLE);
         end else begin
            reply.access_status = STATUS_ERR;
         end
      end else begin
         if (slot == 32'(CELL_OPA)) opa = operand_type'(wdata);
         else if (slot == 32'(CELL_OPB)) opb = operand_type'(wdata);
         else if (slot == 32'(CELL_START)) begin
            if (phase == PH_IDLE) phase = PH_COMPARE;
         end else begin
            reply.access_status = STATUS_ERR;
         end
      end
      awaited_replies.push_back(reply);
   endfunction

   function void check_reply(logic [BUS_WIDTH-1:0] data, logic status);
      bus_reply_type want;
      if (awaited_replies.size() == 0) begin
         $error("reply with no request outstanding: read_data %h access_status %b",
                data, status);
         errors++;
         return;
      end
      want = awaited_replies.pop_front();
      if (data !== want.read_data) begin
         $error("read_data: expected %h, got %h", want.read_data, data);
         errors++;
      end
      if (status !== want.access_status) begin
         $error("access_status: expected %b, got %b", want.access_status, status);
         errors++;
      end
   endfunction
endclass

module gcd_coprocessor_registers_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint SETTLE_LIMIT = 300;
   localparam int     QUIET_CYCLES = 16;
   localparam int     WORDS_PER_PHASE = 360;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [63:0]          req_tdata = '0;
   logic [1:0]           req_tuser = MODE_TICK;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [BUS_WIDTH-1:0] rsp_tdata;
   logic                 rsp_tuser;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [BUS_WIDTH-1:0] csr_data = '0;

   gcd_reply_checker replies = new();
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   int   stall_requests = 0;
   int   stall_served = 0;
   int   hold_left = 0;
   int   words_sent = 0;
   bit   a_set = 1'b0;
   bit   b_set = 1'b0;

   gcd_coprocessor_registers_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_served != stall_requests) begin
         stall_served <= stall_requests;
         hold_left    <= 400;
         rsp_tready   <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) replies.check_reply(rsp_tdata, rsp_tuser);
   end

   initial begin
      #(60_000_000);
      $display("FAILURE");
      $finish;
   end

   task automatic send_word(mode_type mode, logic [31:0] addr, logic [31:0] wdata);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {wdata, addr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      replies.take_bus_word(mode, addr, wdata);
      if (mode != MODE_NONE) words_sent++;
   endtask

   function automatic logic [31:0] slot_address(cell_type slot);
      return replies.base + 32'(slot) * WORD_BYTES_DEFAULT + $urandom_range(0, 3);
   endfunction

   task automatic write_slot(cell_type slot, logic [31:0] value);
      send_word(MODE_WRITE, slot_address(slot), value);
      if (slot == CELL_OPA) a_set = 1'b1;
      if (slot == CELL_OPB) b_set = 1'b1;
   endtask

   task automatic read_slot(cell_type slot);
      send_word(MODE_READ, slot_address(slot), $urandom);
   endtask

   task automatic tick();
      send_word(MODE_TICK, $urandom, $urandom);
   endtask

   task automatic start_engine();
      if (a_set && b_set) write_slot(CELL_START, $urandom);
      else tick();
   endtask

   // Pull the engine to a quick end first where the subtraction loop would run long.
   task automatic read_result();
      if (!(a_set && b_set)) begin
         read_slot(CELL_STATUS);
      end else begin
         if (replies.steps_to_settle() > SETTLE_LIMIT)
            write_slot(CELL_OPA, 32'(replies.opb));
         read_slot(CELL_OPA);
      end
   endtask

   task automatic gcd_job();
      logic [31:0] g, a, b;
      int          m, n, k;
      m = $urandom_range(1, 40);
      n = $urandom_range(1, 40);
      g = $urandom_range(1, 32'h0666_6666);
      a = g * 32'(m);
      b = g * 32'(n);
      if ($urandom_range(99) < 6) a = '0;
      if ($urandom_range(99) < 6) b = '0;
      if ($urandom_range(99) < 5) b = a;
      if ($urandom_range(1)) begin
         write_slot(CELL_OPA, a);
         write_slot(CELL_OPB, b);
      end else begin
         write_slot(CELL_OPB, b);
         write_slot(CELL_OPA, a);
      end
      if ($urandom_range(99) < 30) read_slot(CELL_STATUS);
      start_engine();
      k = $urandom_range(0, 14);
      repeat (k) begin
         if ($urandom_range(99) < 15) read_slot(CELL_STATUS);
         else tick();
      end
      if ($urandom_range(99) < 8)
         write_slot($urandom_range(1) ? CELL_OPA : CELL_OPB, $urandom);
      if ($urandom_range(99) < 8) start_engine();
      read_result();
      if ($urandom_range(99) < 25) read_slot(CELL_STATUS);
   endtask

   task automatic noise_word();
      mode_type    mode;
      logic [31:0] addr, wdata, slot;
      mode  = mode_type'($urandom_range(0, 3));
      wdata = $urandom;
      addr  = $urandom_range(1) ? $urandom : replies.base + $urandom_range(0, 23);
      slot  = (addr - replies.base) / WORD_BYTES_DEFAULT;
      if (mode == MODE_READ && slot == 32'(CELL_OPA)) begin
         read_result();
      end else if (mode == MODE_WRITE && slot == 32'(CELL_START) && !(a_set && b_set)) begin
         tick();
      end else begin
         send_word(mode, addr, wdata);
         if (mode == MODE_WRITE && slot == 32'(CELL_OPA)) a_set = 1'b1;
         if (mode == MODE_WRITE && slot == 32'(CELL_OPB)) b_set = 1'b1;
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (replies.awaited_replies.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic set_base(logic [31:0] value);
      csr_data  <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid    <= 1'b0;
      replies.base = value;
   endtask

   task automatic run_traffic(int stall_at, int drain_at);
      bit stalled, drained;
      stalled    = 1'b0;
      drained    = 1'b0;
      words_sent = 0;
      while (words_sent < WORDS_PER_PHASE) begin
         if (!stalled && stall_at >= 0 && words_sent >= stall_at) begin
            stall_requests <= stall_requests + 1;
            stalled = 1'b1;
         end
         if (!drained && drain_at >= 0 && words_sent >= drain_at) begin
            drain();
            drained = 1'b1;
         end
         if ($urandom_range(99) < 75) gcd_job();
         else noise_word();
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_base(32'h0000_0000);
      read_slot(CELL_STATUS);
      read_slot(CELL_OPB);
      read_slot(CELL_START);
      write_slot(CELL_STATUS, 32'hFFFF_FFFF);
      send_word(MODE_READ, 32'h0000_0010, 32'h0);
      send_word(MODE_WRITE, 32'hFFFF_FFFC, 32'hFFFF_FFFF);
      send_word(MODE_TICK, 32'h0, 32'h0);
      send_word(MODE_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      write_slot(CELL_OPA, 32'hFFFF_FFFF);
      write_slot(CELL_OPB, 32'h5555_5555);
      start_engine();
      tick();
      tick();
      read_slot(CELL_STATUS);
      read_result();
      write_slot(CELL_OPA, 32'h0);
      write_slot(CELL_OPB, 32'h1234_5678);
      start_engine();
      tick();
      read_slot(CELL_STATUS);
      read_result();
      write_slot(CELL_OPA, 32'hFFFF_FFFF);
      write_slot(CELL_OPB, 32'hFFFF_FFFF);
      start_engine();
      read_result();
      write_slot(CELL_OPA, 32'd10);
      write_slot(CELL_OPB, 32'd6);
      start_engine();
      tick();
      write_slot(CELL_OPA, 32'd2);
      tick();
      write_slot(CELL_OPB, 32'h7FFF_FFFE);
      read_result();
      write_slot(CELL_OPA, 32'd12);
      write_slot(CELL_OPB, 32'd18);
      start_engine();
      tick();
      start_engine();
      read_result();
      drain();

      set_base(32'hFFFF_FFFF);
      send_idle_pct = 36;
      recv_idle_pct = 87;
      run_traffic(-1, -1);
      drain();

      set_base($urandom);
      send_idle_pct = 87;
      recv_idle_pct = 36;
      run_traffic(-1, 180);
      drain();

      set_base(32'h8000_0000);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_traffic(120, -1);
      drain();

      if (replies.errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule
